// ===== rtl/mrim_pkg.sv =====
`timescale 1ns / 1ps

package mrim_pkg;

   // Default sizing
   localparam int MAX_DIGITS_DEF = 4;
   localparam int VALUE_BITS_DEF = 16;

   // Fixed port widths
   localparam int SIZE_BITS    = 16;
   localparam int NDIG_BITS    = 3;
   localparam int FIELD_BITS   = 16;
   localparam int PACKED_BITS  = 64;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 64;

   // Register indexes of the control port
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MAP_SIZE     = 2'd0,
      CSR_NUM_DIGITS   = 2'd1,
      CSR_RADICES      = 2'd2,
      CSR_COEFFICIENTS = 2'd3
   } csr_index_type;

   // Sequencer states
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_REM  = 6'b000100,
      ST_ADD  = 6'b001000,
      ST_EMIT = 6'b010000,
      ST_ADV  = 6'b100000
   } state_type;

endpackage

// ===== rtl/mixed_radix_modular_index_map.sv =====
`timescale 1ns / 1ps

// Mixed-radix modular index map.
// Each accepted request (req_valid high, req_stall low) produces one response
// carrying the current linear index, its mapped value (sum of digit times
// coefficient, modulo map_size) and a last flag; the index and its
// mixed-radix digits then advance, wrapping to zero after the last index.
// req_restart clears index and digits before the response is formed.
// Registers are to be written through csr_write_en / csr_index / csr_wdata
// only while the block is idle; the block itself does not enforce this.
// One multiplier shared across digits and two 17-bit compare-subtracts
// (remainder step, modular add) do the work. Per digit in use: a multiply,
// 2*VALUE_BITS remainder steps (one product bit each) and a modular add.
// Then the response register is loaded and the carry steps through the
// digits it touches; the remainder loop dominates. req_stall is high from
// acceptance until the digits have advanced.
// The response sits in an output register; a stalled response only holds
// the block in its emit step, and a new request may be taken while the
// previous response is still waiting. Reset (synchronous) restores
// map_size=1, num_digits=1, zero radices and coefficients, zero index.
module mixed_radix_modular_index_map #(
   parameter int MAX_DIGITS = mrim_pkg::MAX_DIGITS_DEF,
   parameter int VALUE_BITS = mrim_pkg::VALUE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Control registers
   input  logic                               csr_write_en,
   input  logic [mrim_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [mrim_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   // Request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_restart,
   // Response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mrim_pkg::SIZE_BITS-1:0]     rsp_linear_index,
   output logic [mrim_pkg::SIZE_BITS-1:0]     rsp_mapped_value,
   output logic                               rsp_last
);
   import mrim_pkg::*;

   localparam int IDX_BITS  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int ND_BITS   = $clog2(MAX_DIGITS + 1);
   localparam int PROD_BITS = 2 * VALUE_BITS;
   localparam int CNT_BITS  = $clog2(PROD_BITS);

   // Configuration registers
   logic [SIZE_BITS-1:0]   map_size_ff,     map_size_in;
   logic [NDIG_BITS-1:0]   num_digits_ff,   num_digits_in;
   logic [PACKED_BITS-1:0] radices_ff,      radices_in;
   logic [PACKED_BITS-1:0] coefficients_ff, coefficients_in;

   // Count state
   logic [VALUE_BITS-1:0]  digit_ff [MAX_DIGITS];
   logic [VALUE_BITS-1:0]  digit_in [MAX_DIGITS];
   logic [VALUE_BITS-1:0]  position_ff, position_in;

   // Sequencer and datapath
   state_type              state_ff, state_in;
   logic [IDX_BITS-1:0]    dig_idx_ff, dig_idx_in;
   logic [CNT_BITS-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [SIZE_BITS-1:0]   rem_ff, rem_in;
   logic [SIZE_BITS-1:0]   acc_ff, acc_in;

   // Response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SIZE_BITS-1:0]   rsp_index_ff, rsp_index_in;
   logic [SIZE_BITS-1:0]   rsp_value_ff, rsp_value_in;
   logic                   rsp_last_ff,  rsp_last_in;

   // Derived values
   logic [SIZE_BITS-1:0]   size_eff;
   logic [ND_BITS-1:0]     used_digits;
   logic                   req_take;
   logic                   rsp_busy;
   logic                   is_last;
   logic                   last_digit;
   logic [VALUE_BITS-1:0]  digit_cur;
   logic [VALUE_BITS-1:0]  coef_cur;
   logic [VALUE_BITS-1:0]  radix_cur;
   logic [SIZE_BITS:0]     rem_trial;
   logic [SIZE_BITS:0]     acc_sum;
   logic [VALUE_BITS:0]    digit_inc;

   assign size_eff    = (map_size_ff == '0) ? SIZE_BITS'(1) : map_size_ff;
   assign used_digits = (num_digits_ff > NDIG_BITS'(MAX_DIGITS)) ?
                        ND_BITS'(MAX_DIGITS) : ND_BITS'(num_digits_ff);
   assign req_take    = req_valid && !req_stall;
   assign rsp_busy    = rsp_valid_ff && rsp_stall;
   assign is_last     = SIZE_BITS'(position_ff) >= (size_eff - SIZE_BITS'(1));
   assign last_digit  = (ND_BITS'(dig_idx_ff) + ND_BITS'(1)) == used_digits;

   assign digit_cur = digit_ff[dig_idx_ff];
   assign coef_cur  = coefficients_ff[FIELD_BITS*dig_idx_ff +: VALUE_BITS];
   assign radix_cur = radices_ff[FIELD_BITS*dig_idx_ff +: VALUE_BITS];

   // Compare-subtract operands: the remainder step and the modular add
   assign rem_trial = {rem_ff, prod_ff[PROD_BITS-1]};
   assign acc_sum   = {1'b0, acc_ff} + {1'b0, rem_ff};
   assign digit_inc = {1'b0, digit_cur} + (VALUE_BITS+1)'(1);

   assign req_stall = (state_ff != ST_IDLE);

   // Configuration writes
   always_comb begin
      map_size_in     = map_size_ff;
      num_digits_in   = num_digits_ff;
      radices_in      = radices_ff;
      coefficients_in = coefficients_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAP_SIZE:     map_size_in     = csr_wdata[SIZE_BITS-1:0];
            CSR_NUM_DIGITS:   num_digits_in   = csr_wdata[NDIG_BITS-1:0];
            CSR_RADICES:      radices_in      = csr_wdata[PACKED_BITS-1:0];
            CSR_COEFFICIENTS: coefficients_in = csr_wdata[PACKED_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      dig_idx_in   = dig_idx_ff;
      bit_cnt_in   = bit_cnt_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      position_in  = position_ff;
      digit_in     = digit_ff;
      rsp_valid_in = rsp_busy;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_restart) begin
                  for (int k = 0; k < MAX_DIGITS; k++) begin
                     digit_in[k] = '0;
                  end
                  position_in = '0;
               end
               acc_in     = '0;
               dig_idx_in = '0;
               state_in   = (used_digits == '0) ? ST_EMIT : ST_MUL;
            end
         end
         ST_MUL: begin
            // one product per digit on the shared multiplier
            prod_in    = PROD_BITS'(digit_cur) * PROD_BITS'(coef_cur);
            rem_in     = '0;
            bit_cnt_in = CNT_BITS'(PROD_BITS - 1);
            state_in   = ST_REM;
         end
         ST_REM: begin
            // restoring remainder, one product bit per cycle
            if (rem_trial >= {1'b0, size_eff}) begin
               rem_in = SIZE_BITS'(rem_trial - {1'b0, size_eff});
            end else begin
               rem_in = rem_trial[SIZE_BITS-1:0];
            end
            prod_in = prod_ff << 1;
            if (bit_cnt_ff == '0) begin
               state_in = ST_ADD;
            end else begin
               bit_cnt_in = bit_cnt_ff - CNT_BITS'(1);
            end
         end
         ST_ADD: begin
            // both terms below size: one subtract at most
            if (acc_sum >= {1'b0, size_eff}) begin
               acc_in = SIZE_BITS'(acc_sum - {1'b0, size_eff});
            end else begin
               acc_in = acc_sum[SIZE_BITS-1:0];
            end
            if (last_digit) begin
               state_in = ST_EMIT;
            end else begin
               dig_idx_in = dig_idx_ff + IDX_BITS'(1);
               state_in   = ST_MUL;
            end
         end
         ST_EMIT: begin
            if (!rsp_busy) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = SIZE_BITS'(position_ff);
               rsp_value_in = acc_ff;
               rsp_last_in  = is_last;
               if (is_last) begin
                  for (int k = 0; k < MAX_DIGITS; k++) begin
                     digit_in[k] = '0;
                  end
                  position_in = '0;
                  state_in    = ST_IDLE;
               end else begin
                  position_in = position_ff + VALUE_BITS'(1);
                  if (used_digits == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     dig_idx_in = IDX_BITS'(used_digits - ND_BITS'(1));
                     state_in   = ST_ADV;
                  end
               end
            end
         end
         ST_ADV: begin
            // carry ripples one digit per cycle, fastest digit first
            if (digit_inc >= {1'b0, radix_cur}) begin
               digit_in[dig_idx_ff] = VALUE_BITS'(digit_inc - {1'b0, radix_cur});
               if (dig_idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  dig_idx_in = dig_idx_ff - IDX_BITS'(1);
               end
            end else begin
               digit_in[dig_idx_ff] = digit_inc[VALUE_BITS-1:0];
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         map_size_ff     <= SIZE_BITS'(1);
         num_digits_ff   <= NDIG_BITS'(1);
         radices_ff      <= '0;
         coefficients_ff <= '0;
         position_ff     <= '0;
         for (int k = 0; k < MAX_DIGITS; k++) begin
            digit_ff[k] <= '0;
         end
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         map_size_ff     <= map_size_in;
         num_digits_ff   <= num_digits_in;
         radices_ff      <= radices_in;
         coefficients_ff <= coefficients_in;
         position_ff     <= position_in;
         digit_ff        <= digit_in;
      end
   end

   // Datapath and response payload
   always_ff @(posedge clock) begin
      dig_idx_ff   <= dig_idx_in;
      bit_cnt_ff   <= bit_cnt_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      acc_ff       <= acc_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_linear_index = rsp_index_ff;
   assign rsp_mapped_value = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;

   // Checks
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request accepted while sequencer busy");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_restart) |=> (position_ff == '0))
      else $error("restart did not clear the index");

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !rsp_busy && is_last)
         |=> (position_ff == '0 && state_ff == ST_IDLE && rsp_last))
      else $error("index did not wrap after last");

endmodule
